// File: hdl/radial_falloff_mask_stamp_assert.svh
// Assertion macros shared by the checker.
`ifndef RADIAL_FALLOFF_MASK_STAMP_ASSERT_SVH
`define RADIAL_FALLOFF_MASK_STAMP_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define RFMS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rfms_pkg.sv
`default_nettype none

package rfms_pkg;

   // grid geometry
   localparam int MAX_SIDE    = 256;
   localparam int TILE_SIDE   = 16;
   localparam int STORE_CELLS = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W      = $clog2(STORE_CELLS);
   localparam int COORD_W     = $clog2(MAX_SIDE);
   localparam int SIDE_W      = COORD_W + 1;
   localparam int TILE_W      = $clog2(TILE_SIDE);
   localparam int TPR_W       = SIDE_W - TILE_W;
   localparam int CHG_W       = ADDR_W + 1;
   localparam int MAX_STAMP_CELLS = (MAX_SIDE - 2) * (MAX_SIDE - 2);

   // coordinate divider widths
   localparam int DIV_N_W = 23;
   localparam int DIV_D_W = 17;

   // item modes
   localparam logic [1:0] MODE_STAMP = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_SPACING = 3'd0;
   localparam logic [2:0] CSR_COLUMNS = 3'd1;
   localparam logic [2:0] CSR_ROWS    = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_X = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd4;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic [19:0]        stamp_radius;
      logic [15:0]        fade_amount;
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
   } req_type;

   typedef struct packed {
      logic [7:0]       cell_value;
      logic [CHG_W-1:0] cells_changed;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/rfms_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rfms_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rfms_pkg::DIV_N_W-1:0] dividend,
   input  wire logic [rfms_pkg::DIV_D_W-1:0] divisor,
   output logic                             done,
   output logic [rfms_pkg::DIV_N_W-1:0]     quotient,
   output logic                             rem_nonzero
);
   import rfms_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   trial;
   logic                 ge;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      ge      = ~trial[DIV_D_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire

// File: hdl/radial_falloff_mask_stamp.sv
// Radial falloff mask stamp: a 256x256 8-bit mask held in one 64K x 8 synchronous
// RAM laid out in 16x16 tiles, one item in flight at a time. After reset the block
// runs a clearing pass over every cell before it accepts its first item; register
// writes are taken throughout. Read and clear items are bound by the RAM's single
// write port and registered read port. A stamp first runs three bit-serial divisions
// that round the center and radius to cells, then visits each box cell row by row;
// each inside cell is a read-modify-write through the shared multiplier and a 9-step
// falloff divider. A stamp with zero radius or an empty box writes no cell.
`default_nettype none

module radial_falloff_mask_stamp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rfms_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rfms_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [19:0]       csr_wdata
);
   import rfms_pkg::*;

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_CLEAR = 20'h00002,
      ST_RD    = 20'h00004,
      ST_RDW   = 20'h00008,
      ST_DIVS  = 20'h00010,
      ST_DIVW  = 20'h00020,
      ST_BOX   = 20'h00040,
      ST_R2    = 20'h00080,
      ST_DX0   = 20'h00100,
      ST_DY0   = 20'h00200,
      ST_ROW   = 20'h00400,
      ST_SQ    = 20'h00800,
      ST_CMP   = 20'h01000,
      ST_MLO   = 20'h02000,
      ST_MHI   = 20'h04000,
      ST_FPRE  = 20'h08000,
      ST_FDIV  = 20'h10000,
      ST_WR    = 20'h20000,
      ST_ADV   = 20'h40000,
      ST_DONE  = 20'h80000
   } state_type;

   localparam logic [1:0] DIV_CX = 2'd0;
   localparam logic [1:0] DIV_CY = 2'd1;
   localparam logic [1:0] DIV_GR = 2'd2;

   // configuration registers
   logic [15:0]        spacing_ff;
   logic [SIDE_W-1:0]  cols_ff, rows_ff;
   logic signed [19:0] orgx_ff, orgy_ff;

   // control
   state_type          state_ff, state_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [1:0]         dsel_ff, dsel_in;
   logic [3:0]         fstep_ff, fstep_in;

   // item datapath
   logic [7:0]         val_ff, val_in;
   logic [CHG_W-1:0]   chg_ff, chg_in;
   logic signed [20:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [15:0]        s_ff, s_in;
   logic [19:0]        r_ff, r_in;
   logic [23:0]        a_ff, a_in;
   logic signed [23:0] cx_ff, cx_in, cy_ff, cy_in, gr_ff, gr_in;
   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [39:0]        r2_ff, r2_in;
   logic signed [25:0] dx0_ff, dx0_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [49:0]        dy2_ff, dy2_in;
   logic [50:0]        d2_ff, d2_in;
   logic [39:0]        b_ff, b_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [43:0]        p_ff, p_in;
   logic [7:0]         old_ff, old_in;
   logic [63:0]        n_ff, n_in, rem_ff, rem_in, dv_ff, dv_in;
   logic               sat_ff, sat_in;
   logic [8:0]         q_ff, q_in;

   // mask store
   logic [7:0]         mask_mem [STORE_CELLS];
   logic [7:0]         rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [7:0]         mem_wdata;

   // shared datapath nets
   logic [SIDE_W-1:0]  cols_c, rows_c, col_sum, row_sum;
   logic [TPR_W-1:0]   tpr, tpc;
   logic [SIDE_W-1:0]  aw, ah;
   logic [9:0]         tile;
   logic               hit;
   logic [ADDR_W-1:0]  idx;
   logic [24:0]        mul_a, mul_b;
   logic [49:0]        mul_p;
   logic signed [23:0] num;
   logic               num_neg;
   logic [23:0]        num_mag;
   logic               div_start, div_done, div_nz;
   logic [DIV_N_W-1:0] div_q;
   logic [23:0]        q24;
   logic signed [23:0] cq;
   logic signed [24:0] lo_x, hi_x, lo_y, hi_y, lim_x, lim_y, x0s, x1s, y0s, y1s;
   logic [24:0]        dx_mag, dy_mag;
   logic [9:0]         ceil_q;
   logic [7:0]         new_val;
   logic               fge;

   // configuration write port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= 16'd256;
         cols_ff    <= SIDE_W'(MAX_SIDE);
         rows_ff    <= SIDE_W'(MAX_SIDE);
         orgx_ff    <= '0;
         orgy_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPACING:  spacing_ff <= csr_wdata[15:0];
            CSR_COLUMNS:  cols_ff    <= csr_wdata[SIDE_W-1:0];
            CSR_ROWS:     rows_ff    <= csr_wdata[SIDE_W-1:0];
            CSR_ORIGIN_X: orgx_ff    <= csr_wdata;
            CSR_ORIGIN_Y: orgy_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tiled address of (x_ff, y_ff) and its bounds check
   always_comb begin
      cols_c  = (cols_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cols_ff;
      rows_c  = (rows_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : rows_ff;
      col_sum = cols_c + SIDE_W'(TILE_SIDE - 1);
      row_sum = rows_c + SIDE_W'(TILE_SIDE - 1);
      tpr     = col_sum[SIDE_W-1:TILE_W];
      tpc     = row_sum[SIDE_W-1:TILE_W];
      aw      = {tpr, {TILE_W{1'b0}}};
      ah      = {tpc, {TILE_W{1'b0}}};
      tile    = 10'(y_ff[COORD_W-1:TILE_W] * tpr) + 10'(x_ff[COORD_W-1:TILE_W]);
      hit     = ({1'b0, x_ff} < aw) && ({1'b0, y_ff} < ah)
                && (tile < 10'(STORE_CELLS / (TILE_SIDE * TILE_SIDE)));
      idx     = {tile[ADDR_W-2*TILE_W-1:0], y_ff[TILE_W-1:0], x_ff[TILE_W-1:0]};
   end

   // mask RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mask_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mask_mem[idx];
   end

   // shared multiplier, operands chosen by state
   always_comb begin
      dx_mag = dx_ff[25] ? 25'(-dx_ff) : dx_ff[24:0];
      dy_mag = dy_ff[25] ? 25'(-dy_ff) : dy_ff[24:0];
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_R2:  begin mul_a = 25'(r_ff);  mul_b = 25'(r_ff); end
         ST_DX0: begin mul_a = 25'(x0_ff); mul_b = 25'(s_ff); end
         ST_DY0: begin mul_a = 25'(y0_ff); mul_b = 25'(s_ff); end
         ST_ROW: begin mul_a = dy_mag;     mul_b = dy_mag;    end
         ST_SQ:  begin mul_a = dx_mag;     mul_b = dx_mag;    end
         ST_MLO: begin mul_a = 25'(a_ff);  mul_b = 25'(b_ff[19:0]);  end
         ST_MHI: begin mul_a = 25'(a_ff);  mul_b = 25'(b_ff[39:20]); end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // numerator for the rounding divisions: (2*v + s) / (2*s)
   always_comb begin
      case (dsel_ff)
         DIV_CX:  num = $signed({{2{lx_ff[20]}}, lx_ff, 1'b0}) + $signed({8'd0, s_ff});
         DIV_CY:  num = $signed({{2{ly_ff[20]}}, ly_ff, 1'b0}) + $signed({8'd0, s_ff});
         default: num = $signed({3'd0, r_ff, 1'b0}) + $signed({8'd0, s_ff});
      endcase
      num_neg = num[23];
      num_mag = num_neg ? 24'(-num) : 24'(num);
      q24     = {1'b0, div_q};
      cq      = num_neg ? $signed(24'd0 - q24 - {23'd0, div_nz}) : $signed(q24);
   end

   rfms_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (num_mag[DIV_N_W-1:0]),
      .divisor     ({s_ff, 1'b0}),
      .done        (div_done),
      .quotient    (div_q),
      .rem_nonzero (div_nz)
   );

   // stamp box, upper bounds exclusive
   always_comb begin
      lo_x  = $signed({cx_ff[23], cx_ff}) - $signed({gr_ff[23], gr_ff});
      hi_x  = $signed({cx_ff[23], cx_ff}) + $signed({gr_ff[23], gr_ff});
      lo_y  = $signed({cy_ff[23], cy_ff}) - $signed({gr_ff[23], gr_ff});
      hi_y  = $signed({cy_ff[23], cy_ff}) + $signed({gr_ff[23], gr_ff});
      lim_x = $signed({16'd0, cols_c}) - 25'sd1;
      lim_y = $signed({16'd0, rows_c}) - 25'sd1;
      x0s   = (lo_x < 25'sd1) ? 25'sd1 : lo_x;
      y0s   = (lo_y < 25'sd1) ? 25'sd1 : lo_y;
      x1s   = (hi_x < lim_x) ? hi_x : lim_x;
      y1s   = (hi_y < lim_y) ? hi_y : lim_y;
   end

   // falloff: new = max(0, old - ceil(n / (4096 * r2)))
   always_comb begin
      fge     = (rem_ff >= dv_ff);
      ceil_q  = {1'b0, q_ff} + {9'd0, (rem_ff != 64'd0)};
      new_val = (sat_ff || (ceil_q >= {2'b00, old_ff})) ? 8'd0 : (old_ff - ceil_q[7:0]);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_rsp_in   = clr_rsp_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      dsel_in      = dsel_ff;
      fstep_in     = fstep_ff;
      val_in = val_ff;  chg_in = chg_ff;
      lx_in  = lx_ff;   ly_in  = ly_ff;   s_in = s_ff;  r_in = r_ff;  a_in = a_ff;
      cx_in  = cx_ff;   cy_in  = cy_ff;   gr_in = gr_ff;
      x0_in  = x0_ff;   x1_in  = x1_ff;   y0_in = y0_ff; y1_in = y1_ff;
      x_in   = x_ff;    y_in   = y_ff;
      r2_in  = r2_ff;   dx0_in = dx0_ff;  dx_in = dx_ff; dy_in = dy_ff; dy2_in = dy2_ff;
      d2_in  = d2_ff;   b_in   = b_ff;    addr_in = addr_ff;
      p_in   = p_ff;    old_in = old_ff;  n_in = n_ff;
      sat_in = sat_ff;  rem_in = rem_ff;  dv_in = dv_ff; q_in = q_ff;
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = new_val;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in = '0;
               chg_in = '0;
               unique case (req_data.mode)
                  MODE_STAMP: begin
                     lx_in = $signed({req_data.pos_x[19], req_data.pos_x})
                             - $signed({orgx_ff[19], orgx_ff});
                     ly_in = $signed({req_data.pos_y[19], req_data.pos_y})
                             - $signed({orgy_ff[19], orgy_ff});
                     s_in  = (spacing_ff == 16'd0) ? 16'd256 : spacing_ff;
                     r_in  = req_data.stamp_radius;
                     a_in  = {req_data.fade_amount, 8'd0} - {8'd0, req_data.fade_amount};
                     dsel_in  = DIV_CX;
                     state_in = (req_data.stamp_radius == 20'd0) ? ST_DONE : ST_DIVS;
                  end
                  MODE_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  MODE_READ: begin
                     x_in     = req_data.cell_x;
                     y_in     = req_data.cell_y;
                     state_in = ST_RD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = 8'hFF;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == {ADDR_W{1'b1}}) begin
               chg_in   = CHG_W'(STORE_CELLS);
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_RD:  state_in = ST_RDW;
         ST_RDW: begin
            val_in   = hit ? rd_data_ff : 8'd0;
            state_in = ST_DONE;
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               case (dsel_ff)
                  DIV_CX:  cx_in = cq;
                  DIV_CY:  cy_in = cq;
                  default: gr_in = cq;
               endcase
               dsel_in  = dsel_ff + 1'b1;
               state_in = (dsel_ff == DIV_GR) ? ST_BOX : ST_DIVS;
            end
         end
         ST_BOX: begin
            x0_in = x0s[COORD_W-1:0];
            x1_in = x1s[COORD_W-1:0];
            y0_in = y0s[COORD_W-1:0];
            y1_in = y1s[COORD_W-1:0];
            state_in = ((x0s >= x1s) || (y0s >= y1s)) ? ST_DONE : ST_R2;
         end
         ST_R2: begin
            r2_in    = mul_p[39:0];
            state_in = ST_DX0;
         end
         ST_DX0: begin
            dx0_in   = $signed({2'b00, mul_p[23:0]}) - $signed({{5{lx_ff[20]}}, lx_ff});
            state_in = ST_DY0;
         end
         ST_DY0: begin
            dy_in    = $signed({2'b00, mul_p[23:0]}) - $signed({{5{ly_ff[20]}}, ly_ff});
            y_in     = y0_ff;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            dy2_in   = mul_p;
            dx_in    = dx0_ff;
            x_in     = x0_ff;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            d2_in    = {1'b0, mul_p} + {1'b0, dy2_ff};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // RAM read of the cell is launched at this edge
            if ((d2_ff < {11'd0, r2_ff}) && hit) begin
               b_in     = r2_ff - d2_ff[39:0];
               addr_in  = idx;
               state_in = ST_MLO;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_MLO: begin
            p_in     = mul_p[43:0];
            old_in   = rd_data_ff;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            n_in     = {20'd0, p_ff} + {mul_p[43:0], 20'd0};
            state_in = ST_FPRE;
         end
         ST_FPRE: begin
            sat_in   = (n_ff >= {3'd0, r2_ff, 21'd0});
            rem_in   = n_ff;
            dv_in    = {4'd0, r2_ff, 20'd0};
            q_in     = '0;
            fstep_in = '0;
            state_in = ST_FDIV;
         end
         ST_FDIV: begin
            rem_in   = fge ? (rem_ff - dv_ff) : rem_ff;
            q_in     = {q_ff[7:0], fge};
            dv_in    = dv_ff >> 1;
            fstep_in = fstep_ff + 1'b1;
            if (fstep_ff == 4'd8) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            mem_we   = 1'b1;
            chg_in   = chg_ff + 1'b1;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            if (({1'b0, x_ff} + 1'b1) < {1'b0, x1_ff}) begin
               x_in     = x_ff + 1'b1;
               dx_in    = dx_ff + $signed({10'd0, s_ff});
               state_in = ST_SQ;
            end else if (({1'b0, y_ff} + 1'b1) < {1'b0, y1_ff}) begin
               y_in     = y_ff + 1'b1;
               dy_in    = dy_ff + $signed({10'd0, s_ff});
               state_in = ST_ROW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.cell_value    = val_ff;
               rsp_data_in.cells_changed = chg_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_rsp_ff   <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dsel_ff      <= DIV_CX;
         fstep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_rsp_ff   <= clr_rsp_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         dsel_ff      <= dsel_in;
         fstep_ff     <= fstep_in;
      end
      rsp_data_ff <= rsp_data_in;
      val_ff <= val_in;  chg_ff <= chg_in;
      lx_ff  <= lx_in;   ly_ff  <= ly_in;   s_ff <= s_in;  r_ff <= r_in;  a_ff <= a_in;
      cx_ff  <= cx_in;   cy_ff  <= cy_in;   gr_ff <= gr_in;
      x0_ff  <= x0_in;   x1_ff  <= x1_in;   y0_ff <= y0_in; y1_ff <= y1_in;
      x_ff   <= x_in;    y_ff   <= y_in;
      r2_ff  <= r2_in;   dx0_ff <= dx0_in;  dx_ff <= dx_in; dy_ff <= dy_in; dy2_ff <= dy2_in;
      d2_ff  <= d2_in;   b_ff   <= b_in;    addr_ff <= addr_in;
      p_ff   <= p_in;    old_ff <= old_in;  n_ff <= n_in;
      sat_ff <= sat_in;  rem_ff <= rem_in;  dv_ff <= dv_in; q_ff <= q_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/rfms_checker.sv
`default_nettype none

`include "radial_falloff_mask_stamp_assert.svh"

module rfms_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rfms_pkg::rsp_type rsp_data
);
   import rfms_pkg::*;

   // a held result beat keeps its payload
   `RFMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat dropped or changed while stalled")

   // only reads return a value, and reads change nothing
   `RFMS_ASSERT_SAME(a_read_no_change, rsp_valid && (rsp_data.cell_value != 8'd0), rsp_data.cells_changed == '0, "nonzero cell value with cells changed")

   // counts above the largest stamp box come only from a clear
   `RFMS_ASSERT_SAME(a_count_range, rsp_valid && (rsp_data.cells_changed > CHG_W'(MAX_STAMP_CELLS)), rsp_data.cells_changed == CHG_W'(STORE_CELLS), "cells changed out of range")

   // no result beat can appear the cycle after an item is taken
   `RFMS_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall && !rsp_valid, !rsp_valid, "result beat too early after request")

endmodule

bind radial_falloff_mask_stamp rfms_checker u_rfms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
